// ===== hw/rtl/flat_triangle_raster_blend_defines.svh =====
// ----------------------------------------------------------------------------
// flat_triangle_raster_blend assertion macros
// property checks used by the rasterizer sequencer, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef FLAT_TRIANGLE_RASTER_BLEND_DEFINES_SVH
`define FLAT_TRIANGLE_RASTER_BLEND_DEFINES_SVH
`ifndef SYNTH
// check that a property holds at every clock edge outside reset
`define FTRB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check that a condition is followed by another in the next cycle
`define FTRB_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);
`else
`define FTRB_ASSERT(lbl, prop, msg)
`define FTRB_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hw/rtl/ftrb_pkg.sv =====
// ----------------------------------------------------------------------------
// ftrb_pkg
// shared types and constants of the flat triangle rasterizer
// ----------------------------------------------------------------------------
package ftrb_pkg;

   // framebuffer geometry
   localparam int FB_WIDTH  = 256;
   localparam int FB_HEIGHT = 256;
   localparam int FB_SIZE   = FB_WIDTH * FB_HEIGHT;
   localparam int FB_AW     = $clog2(FB_SIZE);
   localparam int PIXW      = FB_AW + 1;

   // field widths
   localparam int CFG_W  = 9;
   localparam int CSR_IW = 3;
   localparam int VW     = 13;
   localparam int YW     = VW + 1;
   localparam int COLW   = 24;
   localparam int IDXW   = 16;
   localparam int FRAC   = 16;
   localparam int NUMW   = VW + FRAC;
   localparam int DENW   = VW;
   localparam int SLW    = NUMW + 1;
   localparam int ACCW   = 46;
   localparam int XW     = ACCW - FRAC;
   localparam int PRW    = SLW + YW;
   localparam int ROWW   = CFG_W;
   localparam int OFFW   = 2 * CFG_W;
   localparam int LOW    = 32;

   typedef enum logic [CSR_IW-1:0] {
      CSR_HCLIP       = 3'd0,
      CSR_CLIP_RIGHT  = 3'd1,
      CSR_CLIP_BOTTOM = 3'd2,
      CSR_TRANSP      = 3'd3,
      CSR_ROW_STRIDE  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      SLOPE_AB,
      SLOPE_BC,
      SLOPE_CA
   } slope_sel_type;

   typedef enum logic [1:0] {
      ADJ_L,
      ADJ_S,
      ADJ_M
   } adj_sel_type;

   typedef enum logic [1:0] {
      WALK_TIE_A,
      WALK_TIE_B,
      WALK_LT,
      WALK_NOT_GT
   } walk_mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SETUP,
      ST_ADJ,
      ST_ADJ_FIN,
      ST_ROW_CHK,
      ST_SPAN,
      ST_BOUND,
      ST_PIX,
      ST_PIX_WR,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic          clr_wr;
      logic          load_req;
      logic          rd_item;
      logic          div_start;
      slope_sel_type div_sel;
      logic          div_store;
      logic          setup;
      logic          adj_en;
      adj_sel_type   adj_sel;
      logic          adj_fin;
      logic          span;
      logic          bound;
      logic          pix_rd;
      logic          pix_wr;
      logic          rsp_load;
   } ftrb_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic skip;
      logic row_more;
      logic pix_done;
      logic blend;
   } ftrb_sts_type;

endpackage

// ===== hw/rtl/ftrb_div.sv =====
// ----------------------------------------------------------------------------
// ftrb_div
// restoring divider, one quotient bit per cycle, unsigned operands
// ----------------------------------------------------------------------------
module ftrb_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ftrb_pkg::NUMW-1:0] num,
   input  logic [ftrb_pkg::DENW-1:0] den,
   output logic                      done,
   output logic [ftrb_pkg::NUMW-1:0] quo
);
   import ftrb_pkg::*;

   localparam int CNTW = $clog2(NUMW);

   logic            busy_ff;
   logic            done_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [DENW:0]   rem_ff;
   logic [NUMW-1:0] quo_ff;
   logic [DENW-1:0] den_ff;
   logic [DENW:0]   trial;
   logic            fits;

   assign trial = {rem_ff[DENW-1:0], quo_ff[NUMW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(NUMW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= fits ? (trial - {1'b0, den_ff}) : trial;
         quo_ff <= {quo_ff[NUMW-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== hw/rtl/ftrb_datapath.sv =====
// ----------------------------------------------------------------------------
// ftrb_datapath
// edge setup, scanline stepping, span bounds, blend and framebuffer memory
// ----------------------------------------------------------------------------
module ftrb_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  ftrb_pkg::ftrb_cmd_type         cmd,
   output ftrb_pkg::ftrb_sts_type         sts,
   input  logic                           csr_wr_en,
   input  logic [ftrb_pkg::CSR_IW-1:0]    csr_index,
   input  logic [ftrb_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                           req_action,
   input  logic signed [ftrb_pkg::VW-1:0] req_vx_a,
   input  logic signed [ftrb_pkg::VW-1:0] req_vx_b,
   input  logic signed [ftrb_pkg::VW-1:0] req_vx_c,
   input  logic signed [ftrb_pkg::VW-1:0] req_vy_a,
   input  logic signed [ftrb_pkg::VW-1:0] req_vy_b,
   input  logic signed [ftrb_pkg::VW-1:0] req_vy_c,
   input  logic [ftrb_pkg::COLW-1:0]      req_fill_colour,
   input  logic [ftrb_pkg::IDXW-1:0]      req_pixel_index,
   output logic [ftrb_pkg::COLW-1:0]      rsp_read_pixel,
   output logic                           rsp_was_read
);
   import ftrb_pkg::*;

   function automatic logic signed [YW-1:0] min_y(input logic signed [YW-1:0] v,
                                                  input logic signed [YW-1:0] c);
      return (v > c) ? c : v;
   endfunction

   function automatic logic [PIXW-1:0] clamp_fb(input logic signed [LOW-1:0] v);
      logic [PIXW-1:0] r;
      if (v < 0)
         r = '0;
      else if (v > $signed(LOW'(FB_SIZE)))
         r = PIXW'(FB_SIZE);
      else
         r = v[PIXW-1:0];
      return r;
   endfunction

   // configuration
   logic             hclip_ff;
   logic [CFG_W-1:0] clip_right_ff;
   logic [CFG_W-1:0] clip_bottom_ff;
   logic [CFG_W-1:0] transp_ff;
   logic [CFG_W-1:0] stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hclip_ff       <= 1'b1;
         clip_right_ff  <= CFG_W'(256);
         clip_bottom_ff <= CFG_W'(256);
         transp_ff      <= '0;
         stride_ff      <= CFG_W'(256);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_HCLIP:       hclip_ff       <= csr_wdata[0];
            CSR_CLIP_RIGHT:  clip_right_ff  <= csr_wdata;
            CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata;
            CSR_TRANSP:      transp_ff      <= csr_wdata;
            CSR_ROW_STRIDE:  stride_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request capture
   logic                 action_ff;
   logic signed [VW-1:0] vx_ff [3];
   logic signed [VW-1:0] vy_ff [3];
   logic [COLW-1:0]      colour_ff;
   logic [IDXW-1:0]      index_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= req_action;
         vx_ff[0]  <= req_vx_a;
         vx_ff[1]  <= req_vx_b;
         vx_ff[2]  <= req_vx_c;
         vy_ff[0]  <= req_vy_a;
         vy_ff[1]  <= req_vy_b;
         vy_ff[2]  <= req_vy_c;
         colour_ff <= req_fill_colour;
         index_ff  <= req_pixel_index;
      end
   end

   // slope division
   logic signed [VW-1:0] d_x0, d_x1, d_y0, d_y1;
   logic signed [YW-1:0] dx_w, dy_w;
   logic [YW-1:0]        dx_mag, dy_mag;
   logic [NUMW-1:0]      div_num;
   logic [DENW-1:0]      div_den;
   logic                 div_done;
   logic [NUMW-1:0]      div_quo;
   logic                 neg_ff;
   logic                 zero_ff;
   slope_sel_type        sel_ff;
   logic signed [SLW-1:0] s_ab_ff, s_bc_ff, s_ca_ff, s_new;
   logic [SLW-1:0]       s_mag;

   always_comb begin
      case (cmd.div_sel)
         SLOPE_AB: begin
            d_x0 = vx_ff[0]; d_y0 = vy_ff[0]; d_x1 = vx_ff[1]; d_y1 = vy_ff[1];
         end
         SLOPE_BC: begin
            d_x0 = vx_ff[1]; d_y0 = vy_ff[1]; d_x1 = vx_ff[2]; d_y1 = vy_ff[2];
         end
         default: begin
            d_x0 = vx_ff[2]; d_y0 = vy_ff[2]; d_x1 = vx_ff[0]; d_y1 = vy_ff[0];
         end
      endcase
      dx_w    = {d_x1[VW-1], d_x1} - {d_x0[VW-1], d_x0};
      dy_w    = {d_y1[VW-1], d_y1} - {d_y0[VW-1], d_y0};
      dx_mag  = dx_w[YW-1] ? (~dx_w + 1'b1) : dx_w;
      dy_mag  = dy_w[YW-1] ? (~dy_w + 1'b1) : dy_w;
      div_num = {dx_mag[VW-1:0], {FRAC{1'b0}}};
      div_den = dy_mag[DENW-1:0];
   end

   ftrb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign s_mag = {1'b0, div_quo};
   assign s_new = zero_ff ? '0 : (neg_ff ? -$signed(s_mag) : $signed(s_mag));

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff  <= dx_w[YW-1] ^ dy_w[YW-1];
         zero_ff <= (dy_w == '0);
         sel_ff  <= cmd.div_sel;
      end
      if (cmd.div_store) begin
         case (sel_ff)
            SLOPE_AB: s_ab_ff <= s_new;
            SLOPE_BC: s_bc_ff <= s_new;
            default:  s_ca_ff <= s_new;
         endcase
      end
   end

   // vertex sort and bottom clip
   logic signed [YW-1:0]  ya, yb, yc, cb, ya_c, yb_c, yc_c;
   logic signed [VW-1:0]  su_xt, su_xm;
   logic signed [YW-1:0]  su_yt, su_ym, su_yb;
   logic signed [SLW-1:0] su_sl, su_ss, su_sm;
   walk_mode_type         su_mode;
   logic                  su_skip;

   always_comb begin
      ya   = {vy_ff[0][VW-1], vy_ff[0]};
      yb   = {vy_ff[1][VW-1], vy_ff[1]};
      yc   = {vy_ff[2][VW-1], vy_ff[2]};
      cb   = $signed({{(YW-CFG_W){1'b0}}, clip_bottom_ff});
      ya_c = min_y(ya, cb);
      yb_c = min_y(yb, cb);
      yc_c = min_y(yc, cb);
      if (ya <= yb && ya <= yc) begin
         su_skip = ya >= cb;
         su_xt   = vx_ff[0];
         su_yt   = ya;
         if (yb_c < yc_c) begin
            su_xm = vx_ff[1]; su_ym = yb_c; su_yb = yc_c;
            su_sl = s_ca_ff; su_ss = s_ab_ff; su_sm = s_bc_ff; su_mode = WALK_TIE_A;
         end else begin
            su_xm = vx_ff[2]; su_ym = yc_c; su_yb = yb_c;
            su_sl = s_ab_ff; su_ss = s_ca_ff; su_sm = s_bc_ff; su_mode = WALK_TIE_B;
         end
      end else if (yb <= yc) begin
         su_skip = yb >= cb;
         su_xt   = vx_ff[1];
         su_yt   = yb;
         if (yc_c < ya_c) begin
            su_xm = vx_ff[2]; su_ym = yc_c; su_yb = ya_c;
            su_sl = s_ab_ff; su_ss = s_bc_ff; su_sm = s_ca_ff; su_mode = WALK_TIE_A;
         end else begin
            su_xm = vx_ff[0]; su_ym = ya_c; su_yb = yc_c;
            su_sl = s_bc_ff; su_ss = s_ab_ff; su_sm = s_ca_ff; su_mode = WALK_NOT_GT;
         end
      end else begin
         su_skip = yc >= cb;
         su_xt   = vx_ff[2];
         su_yt   = yc;
         if (ya_c < yb_c) begin
            su_xm = vx_ff[0]; su_ym = ya_c; su_yb = yb_c;
            su_sl = s_bc_ff; su_ss = s_ca_ff; su_sm = s_ab_ff; su_mode = WALK_LT;
         end else begin
            su_xm = vx_ff[1]; su_ym = yb_c; su_yb = ya_c;
            su_sl = s_ca_ff; su_ss = s_bc_ff; su_sm = s_ab_ff; su_mode = WALK_NOT_GT;
         end
      end
   end

   // edge walk registers
   logic signed [YW-1:0]   yt_ff, ym_ff, ybot_ff;
   logic signed [SLW-1:0]  sl_ff, ss_ff, sm_ff;
   walk_mode_type          mode_ff;
   logic                   skip_ff;
   logic                   long_left_ff;
   logic signed [ACCW-1:0] acc_l_ff, acc_s_ff, acc_m_ff;
   logic [ROWW-1:0]        row_y_ff;
   logic [OFFW-1:0]        off_ff;

   // clip to row zero
   logic signed [SLW-1:0]  mul_a;
   logic signed [YW-1:0]   mul_b;
   logic signed [PRW-1:0]  prod;
   logic signed [ACCW-1:0] prod_x;
   logic                   mul_neg;
   logic signed [YW-1:0]   yt_c, ym_c;
   logic                   y_ne, ll_new;

   always_comb begin
      case (cmd.adj_sel)
         ADJ_L:   begin mul_a = sl_ff; mul_b = yt_ff; end
         ADJ_S:   begin mul_a = ss_ff; mul_b = yt_ff; end
         default: begin mul_a = sm_ff; mul_b = ym_ff; end
      endcase
      mul_neg = mul_b[YW-1];
      prod    = mul_a * mul_b;
      prod_x  = {{(ACCW-PRW){prod[PRW-1]}}, prod};
      yt_c    = yt_ff[YW-1] ? '0 : yt_ff;
      ym_c    = ym_ff[YW-1] ? '0 : ym_ff;
      y_ne    = yt_c != ym_c;
      case (mode_ff)
         WALK_TIE_A: ll_new = (y_ne && sl_ff < ss_ff) || (!y_ne && sl_ff > sm_ff);
         WALK_TIE_B: ll_new = !((y_ne && ss_ff < sl_ff) || (!y_ne && sm_ff > sl_ff));
         WALK_LT:    ll_new = sl_ff < ss_ff;
         default:    ll_new = !(ss_ff < sl_ff);
      endcase
   end

   // span of the current row
   logic                   in_ph1, in_ph2;
   logic signed [YW-1:0]   row_s;
   logic signed [ACCW-1:0] acc_o;
   logic signed [XW-1:0]   x_l, x_o, x_a, x_b, x_cr;
   logic signed [XW-1:0]   span_a_ff, span_b_ff;
   logic signed [LOW-1:0]  lo_w, hi_w;
   logic [PIXW-1:0]        pix_ff, hi_ff;

   always_comb begin
      row_s  = $signed({{(YW-ROWW){1'b0}}, row_y_ff});
      in_ph1 = row_s < ym_ff;
      in_ph2 = row_s < ybot_ff;
      acc_o  = in_ph1 ? acc_s_ff : acc_m_ff;
      x_l    = acc_l_ff[ACCW-1:FRAC];
      x_o    = acc_o[ACCW-1:FRAC];
      x_a    = long_left_ff ? x_l : x_o;
      x_b    = long_left_ff ? x_o : x_l;
      x_cr   = $signed({{(XW-CFG_W){1'b0}}, clip_right_ff});
      if (hclip_ff) begin
         if (x_b > x_cr)
            x_b = x_cr;
         if (x_a < 0)
            x_a = '0;
      end
      lo_w = $signed({{(LOW-OFFW){1'b0}}, off_ff})
           + $signed({{(LOW-XW){span_a_ff[XW-1]}}, span_a_ff});
      hi_w = $signed({{(LOW-OFFW){1'b0}}, off_ff})
           + $signed({{(LOW-XW){span_b_ff[XW-1]}}, span_b_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         yt_ff    <= su_yt;
         ym_ff    <= su_ym;
         ybot_ff  <= su_yb;
         sl_ff    <= su_sl;
         ss_ff    <= su_ss;
         sm_ff    <= su_sm;
         mode_ff  <= su_mode;
         acc_l_ff <= {{(ACCW-VW-FRAC){su_xt[VW-1]}}, su_xt, {FRAC{1'b0}}};
         acc_s_ff <= {{(ACCW-VW-FRAC){su_xt[VW-1]}}, su_xt, {FRAC{1'b0}}};
         acc_m_ff <= {{(ACCW-VW-FRAC){su_xm[VW-1]}}, su_xm, {FRAC{1'b0}}};
      end else if (cmd.adj_en) begin
         if (mul_neg) begin
            case (cmd.adj_sel)
               ADJ_L:   acc_l_ff <= acc_l_ff - prod_x;
               ADJ_S:   acc_s_ff <= acc_s_ff - prod_x;
               default: acc_m_ff <= acc_m_ff - prod_x;
            endcase
         end
      end else if (cmd.adj_fin) begin
         yt_ff        <= yt_c;
         ym_ff        <= ym_c;
         long_left_ff <= ll_new;
         row_y_ff     <= yt_c[ROWW-1:0];
         off_ff       <= yt_c[ROWW-1:0] * stride_ff;
      end else if (cmd.bound) begin
         // step the edges to the next scanline
         acc_l_ff <= acc_l_ff + {{(ACCW-SLW){sl_ff[SLW-1]}}, sl_ff};
         if (in_ph1)
            acc_s_ff <= acc_s_ff + {{(ACCW-SLW){ss_ff[SLW-1]}}, ss_ff};
         else
            acc_m_ff <= acc_m_ff + {{(ACCW-SLW){sm_ff[SLW-1]}}, sm_ff};
         off_ff   <= off_ff + {{(OFFW-CFG_W){1'b0}}, stride_ff};
         row_y_ff <= row_y_ff + 1'b1;
      end
      if (cmd.span) begin
         span_a_ff <= x_a;
         span_b_ff <= x_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b0;
         pix_ff  <= '0;
         hi_ff   <= '0;
      end else begin
         if (cmd.setup)
            skip_ff <= su_skip;
         if (cmd.bound) begin
            if (span_a_ff < span_b_ff) begin
               pix_ff <= clamp_fb(lo_w);
               hi_ff  <= clamp_fb(hi_w);
            end else begin
               pix_ff <= '0;
               hi_ff  <= '0;
            end
         end else if (cmd.pix_wr) begin
            pix_ff <= pix_ff + 1'b1;
         end
      end
   end

   // blend
   logic [CFG_W-1:0] t_w, it_w;
   logic [COLW-1:0]  rd_data_ff;
   logic [COLW-1:0]  blend_px;
   logic [16:0]      pc, po;

   always_comb begin
      t_w  = (transp_ff > CFG_W'(256)) ? CFG_W'(256) : transp_ff;
      it_w = CFG_W'(256) - t_w;
      for (int ch = 0; ch < 3; ch++) begin
         pc = colour_ff[ch*8 +: 8] * it_w;
         po = rd_data_ff[ch*8 +: 8] * t_w;
         blend_px[ch*8 +: 8] = pc[15:8] + po[15:8];
      end
   end

   // framebuffer memory
   logic [COLW-1:0]  fb_mem [FB_SIZE];
   logic [FB_AW-1:0] clr_addr_ff;
   logic             wr_en;
   logic [FB_AW-1:0] wr_addr, rd_addr;
   logic [COLW-1:0]  wr_data;
   logic             rd_ok;

   assign wr_en   = cmd.clr_wr | cmd.pix_wr;
   assign wr_addr = cmd.clr_wr ? clr_addr_ff : pix_ff[FB_AW-1:0];
   assign wr_data = cmd.clr_wr ? '0 : ((t_w != '0) ? blend_px : colour_ff);
   assign rd_addr = cmd.rd_item ? FB_AW'(index_ff) : pix_ff[FB_AW-1:0];
   assign rd_ok   = LOW'(index_ff) < LOW'(FB_SIZE);

   always_ff @(posedge clock) begin
      if (wr_en)
         fb_mem[wr_addr] <= wr_data;
      if (cmd.rd_item || cmd.pix_rd)
         rd_data_ff <= fb_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset)
         clr_addr_ff <= '0;
      else if (cmd.clr_wr)
         clr_addr_ff <= clr_addr_ff + 1'b1;
   end

   // response payload
   logic [COLW-1:0] rsp_pixel_ff;
   logic            rsp_read_ff;

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_pixel_ff <= (action_ff && rd_ok) ? rd_data_ff : '0;
         rsp_read_ff  <= action_ff;
      end
   end

   assign rsp_read_pixel = rsp_pixel_ff;
   assign rsp_was_read   = rsp_read_ff;

   always_comb begin
      sts.clr_last = clr_addr_ff == FB_AW'(FB_SIZE - 1);
      sts.div_done = div_done;
      sts.skip     = skip_ff;
      sts.row_more = in_ph1 || in_ph2;
      sts.pix_done = pix_ff >= hi_ff;
      sts.blend    = t_w != '0;
   end

endmodule

// ===== hw/rtl/ftrb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ftrb_ctrl
// sequencer for clear, read, slope division, edge setup and span fill
// ----------------------------------------------------------------------------
`include "flat_triangle_raster_blend_defines.svh"

module ftrb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_action,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output ftrb_pkg::ftrb_cmd_type cmd,
   input  ftrb_pkg::ftrb_sts_type sts
);
   import ftrb_pkg::*;

   ctrl_state_type st_ff, st_in;
   slope_sel_type  div_k_ff, div_k_in;
   adj_sel_type    adj_k_ff, adj_k_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         div_k_ff     <= SLOPE_AB;
         adj_k_ff     <= ADJ_L;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         div_k_ff     <= div_k_in;
         adj_k_ff     <= adj_k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      st_in        = st_ff;
      div_k_in     = div_k_ff;
      adj_k_in     = adj_k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.div_sel  = div_k_ff;
      cmd.adj_sel  = adj_k_ff;
      req_tready   = 1'b0;
      case (st_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last)
               st_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               div_k_in     = SLOPE_AB;
               st_in        = req_action ? ST_READ : ST_DIV_GO;
            end
         end
         ST_READ: begin
            cmd.rd_item = 1'b1;
            st_in       = ST_DONE;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            st_in         = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               case (div_k_ff)
                  SLOPE_AB: begin div_k_in = SLOPE_BC; st_in = ST_DIV_GO; end
                  SLOPE_BC: begin div_k_in = SLOPE_CA; st_in = ST_DIV_GO; end
                  default:  st_in = ST_SETUP;
               endcase
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            adj_k_in  = ADJ_L;
            st_in     = ST_ADJ;
         end
         ST_ADJ: begin
            cmd.adj_en = 1'b1;
            case (adj_k_ff)
               ADJ_L:   adj_k_in = ADJ_S;
               ADJ_S:   adj_k_in = ADJ_M;
               default: st_in = ST_ADJ_FIN;
            endcase
         end
         ST_ADJ_FIN: begin
            cmd.adj_fin = 1'b1;
            st_in       = ST_ROW_CHK;
         end
         ST_ROW_CHK: begin
            if (sts.skip || !sts.row_more)
               st_in = ST_DONE;
            else
               st_in = ST_SPAN;
         end
         ST_SPAN: begin
            cmd.span = 1'b1;
            st_in    = ST_BOUND;
         end
         ST_BOUND: begin
            cmd.bound = 1'b1;
            st_in     = ST_PIX;
         end
         ST_PIX: begin
            if (sts.pix_done) begin
               st_in = ST_ROW_CHK;
            end else if (sts.blend) begin
               cmd.pix_rd = 1'b1;
               st_in      = ST_PIX_WR;
            end else begin
               cmd.pix_wr = 1'b1;
            end
         end
         ST_PIX_WR: begin
            cmd.pix_wr = 1'b1;
            st_in      = ST_PIX;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   `FTRB_ASSERT(a_div_done_in_wait, sts.div_done |-> (st_ff == ST_DIV_WAIT), "divider finished outside its wait state")
   `FTRB_ASSERT(a_pix_wr_in_span, cmd.pix_wr |-> !sts.pix_done, "pixel written past the span end")
   `FTRB_ASSERT_NEXT(a_req_leaves_idle, req_tvalid && req_tready, st_ff != ST_IDLE, "accepted request did not start work")

endmodule

// ===== hw/rtl/flat_triangle_raster_blend.sv =====
// ----------------------------------------------------------------------------
// flat_triangle_raster_blend
// flat shaded triangle rasterizer with transparency blend into a local frame
// ----------------------------------------------------------------------------
// After reset the block sweeps the 65536-entry framebuffer to zero, one pixel
// per clock, and takes no request until that is done; register writes are
// taken at any time. A read request reads the framebuffer, then loads the
// result into the output register. A draw request runs three signed 14.16
// edge slope divisions on one shared bit-serial divider, then edge setup and
// clipping to row zero, then per scanline a span computation and bound; an
// opaque pixel is written directly, while a blended pixel is first read from
// the framebuffer and then written back with the blend. One request is in
// work at a time; the next one is taken while a result still waits in the
// output register.
// ----------------------------------------------------------------------------
module flat_triangle_raster_blend (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // vx_a, vx_b, vx_c, vy_a, vy_b, vy_c, fill_colour, pixel_index, pad
   input  logic [119:0]                  req_tdata,
   // action
   input  logic                          req_tuser,
   // response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // read_pixel
   output logic [ftrb_pkg::COLW-1:0]     rsp_tdata,
   // was_read
   output logic                          rsp_tuser,
   // register write port
   input  logic                          csr_wr_en,
   input  logic [ftrb_pkg::CSR_IW-1:0]   csr_index,
   input  logic [ftrb_pkg::CFG_W-1:0]    csr_wdata
);
   import ftrb_pkg::*;

   ftrb_cmd_type cmd;
   ftrb_sts_type sts;

   // request field unpack, lowest field first
   logic signed [VW-1:0] vx_a, vx_b, vx_c, vy_a, vy_b, vy_c;
   logic [COLW-1:0]      fill_colour;
   logic [IDXW-1:0]      pixel_index;

   assign vx_a        = req_tdata[0*VW +: VW];
   assign vx_b        = req_tdata[1*VW +: VW];
   assign vx_c        = req_tdata[2*VW +: VW];
   assign vy_a        = req_tdata[3*VW +: VW];
   assign vy_b        = req_tdata[4*VW +: VW];
   assign vy_c        = req_tdata[5*VW +: VW];
   assign fill_colour = req_tdata[6*VW +: COLW];
   assign pixel_index = req_tdata[6*VW+COLW +: IDXW];

   // sequencer: owns the handshakes and the output valid
   ftrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // datapath: registers, edge math, blend and framebuffer
   ftrb_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_action      (req_tuser),
      .req_vx_a        (vx_a),
      .req_vx_b        (vx_b),
      .req_vx_c        (vx_c),
      .req_vy_a        (vy_a),
      .req_vy_b        (vy_b),
      .req_vy_c        (vy_c),
      .req_fill_colour (fill_colour),
      .req_pixel_index (pixel_index),
      .rsp_read_pixel  (rsp_tdata),
      .rsp_was_read    (rsp_tuser)
   );

endmodule
